### rtl/tdfa_pkg.sv
// ----------------------------------------------------------------------------
// tdfa_pkg
// Shared types and constants for the table-driven automaton recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdfa_pkg;

	localparam int NUM_STATES  = 16;
	localparam int STATE_W     = $clog2(NUM_STATES);
	localparam int SYM_W       = 8;
	localparam int NUM_SYMS    = 1 << SYM_W;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ENTRY_W     = STATE_W + SYM_W + STATE_W;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 3'd0,
		OP_ALPHA  = 3'd1,
		OP_START  = 3'd2,
		OP_SYMBOL = 3'd3,
		OP_END    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED      = 2'd0,
		ST_UNKNOWN_SYM   = 2'd1,
		ST_NO_TRANS      = 2'd2,
		ST_NOT_ACCEPTING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE   = 2'd0,
		FSM_SEARCH = 2'd1,
		FSM_HOLD   = 2'd2
	} fsm_t;

	localparam logic [CFG_IDX_W-1:0] CFG_START_STATE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_COUNT = 2'd2;

endpackage

`default_nettype wire

### rtl/tdfa_ram.sv
// ----------------------------------------------------------------------------
// tdfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/table_driven_dfa_recognizer_unit.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_recognizer_unit
// Table-driven automaton acceptor: a sequencer walks the transition table
// one entry per cycle through a single RAM read port.
// ----------------------------------------------------------------------------
// load, alphabet and start items never stall the input; a symbol item stalls it
// while up to min(transition_count, 64) table entries are walked, one table
// entry compared per cycle through the table RAM read port
// end result is registered and appears the cycle after the end item transfer,
// or once the receiver takes an unread earlier result, input stalled meanwhile
// reset clears config registers, state, latched error and alphabet; table unknown until loaded
`default_nettype none

module table_driven_dfa_recognizer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tdfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tdfa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// entry_index[5:0], from_state[9:6], symbol[17:10], to_state[21:18], zero pad
	input  wire logic [tdfa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// op[2:0]
	input  wire logic [tdfa_pkg::OP_W-1:0]        s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// status[1:0], end_state[5:2], zero pad
	output logic      [tdfa_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	import tdfa_pkg::*;

	fsm_t                 state_q;
	fsm_t                 state_d;
	logic [STATE_W-1:0]   start_q;
	logic [NUM_STATES-1:0] accept_q;
	logic [CNT_W-1:0]     count_q;
	logic [STATE_W-1:0]   cur_q;
	status_t              err_q;
	logic [NUM_SYMS-1:0]  alpha_q;
	logic [SYM_W-1:0]     sym_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 cmp_valid_q;
	logic                 cmp_last_q;
	logic [CNT_W-1:0]     limit_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [STATE_W-1:0]   out_state_q;

	op_t                  in_op;
	logic [IDX_W-1:0]     in_idx;
	logic [STATE_W-1:0]   in_from;
	logic [SYM_W-1:0]     in_sym;
	logic [STATE_W-1:0]   in_to;
	logic                 in_xfer;
	logic [CNT_W-1:0]     limit_d;
	logic                 out_free;
	logic                 sym_known;
	logic                 start_search;
	logic                 load_result;
	logic                 tbl_we;
	logic                 tbl_re;
	logic [ENTRY_W-1:0]   tbl_rdata;
	logic                 hit;
	logic                 miss;
	status_t              result_status;

	assign in_op   = op_t'(s_axis_tuser);
	assign in_idx  = s_axis_tdata[IDX_W-1:0];
	assign in_from = s_axis_tdata[IDX_W+STATE_W-1:IDX_W];
	assign in_sym  = s_axis_tdata[IDX_W+STATE_W+SYM_W-1:IDX_W+STATE_W];
	assign in_to   = s_axis_tdata[IDX_W+2*STATE_W+SYM_W-1:IDX_W+STATE_W+SYM_W];

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign limit_d   = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;
	assign sym_known = alpha_q[in_sym];

	assign hit = cmp_valid_q
		&& (tbl_rdata[ENTRY_W-1:ENTRY_W-STATE_W] == cur_q)
		&& (tbl_rdata[STATE_W+SYM_W-1:STATE_W] == sym_q);
	assign miss = cmp_valid_q && !hit && cmp_last_q;

	always_comb begin
		if (err_q != ST_ACCEPTED) begin
			result_status = err_q;
		end else if (accept_q[cur_q]) begin
			result_status = ST_ACCEPTED;
		end else begin
			result_status = ST_NOT_ACCEPTING;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_xfer && in_op == OP_SYMBOL && err_q == ST_ACCEPTED && sym_known
					&& limit_d != '0) begin
					state_d = FSM_SEARCH;
				end else if (in_xfer && in_op == OP_END && !out_free) begin
					state_d = FSM_HOLD;
				end
			end
			FSM_SEARCH: begin
				if (hit || miss) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_HOLD: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		start_search  = 1'b0;
		load_result   = 1'b0;
		tbl_we        = 1'b0;
		tbl_re        = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_axis_tready = 1'b1;
				start_search  = in_xfer && in_op == OP_SYMBOL && err_q == ST_ACCEPTED
					&& sym_known && limit_d != '0;
				load_result   = in_xfer && in_op == OP_END && out_free;
				tbl_we        = in_xfer && in_op == OP_LOAD
					&& ({1'b0, in_idx} < CNT_W'(TABLE_DEPTH));
			end
			FSM_SEARCH: begin
				tbl_re = !(hit || miss);
			end
			FSM_HOLD: begin
				load_result = out_free;
			end
			default: begin
			end
		endcase
	end

	tdfa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(in_idx),
		.wdata({in_from, in_sym, in_to}),
		.re   (tbl_re),
		.raddr(rd_idx_q),
		.rdata(tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			accept_q <= '0;
			count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_STATE:      start_q  <= cfg_wdata[STATE_W-1:0];
				CFG_ACCEPT_MASK:      accept_q <= cfg_wdata[NUM_STATES-1:0];
				CFG_TRANSITION_COUNT: count_q  <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			cur_q       <= '0;
			err_q       <= ST_ACCEPTED;
			alpha_q     <= '0;
			rd_idx_q    <= '0;
			cmp_valid_q <= 1'b0;
			cmp_last_q  <= 1'b0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == FSM_IDLE && in_xfer) begin
				case (in_op)
					OP_ALPHA: begin
						alpha_q[in_sym] <= 1'b1;
					end
					OP_START: begin
						cur_q <= start_q;
						err_q <= ST_ACCEPTED;
					end
					OP_SYMBOL: begin
						if (err_q == ST_ACCEPTED) begin
							if (!sym_known) begin
								err_q <= ST_UNKNOWN_SYM;
							end else if (limit_d == '0) begin
								err_q <= ST_NO_TRANS;
							end
						end
					end
					default: begin
					end
				endcase
			end

			// table walk: each address is issued in the cycle before its compare
			if (start_search) begin
				rd_idx_q    <= '0;
				cmp_valid_q <= 1'b0;
				cmp_last_q  <= 1'b0;
				limit_q     <= limit_d;
			end else if (state_q == FSM_SEARCH) begin
				if (hit) begin
					cur_q       <= tbl_rdata[STATE_W-1:0];
					cmp_valid_q <= 1'b0;
				end else if (miss) begin
					err_q       <= ST_NO_TRANS;
					cmp_valid_q <= 1'b0;
				end else begin
					rd_idx_q    <= rd_idx_q + 1'b1;
					cmp_valid_q <= 1'b1;
					cmp_last_q  <= ({1'b0, rd_idx_q} == limit_q - 1'b1);
				end
			end

			if (load_result) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_search) begin
			sym_q <= in_sym;
		end
		if (load_result) begin
			out_status_q <= result_status;
			out_state_q  <= cur_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-STATUS_W-STATE_W){1'b0}}, out_state_q, out_status_q};

endmodule

`default_nettype wire
